// ===== src/lvn_pkg.sv =====
// lvn_pkg: widths, codes and the token word that travels down the cell chain
// of the local value numbering table. No dependencies.
package lvn_pkg;

  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IMM_BITS    = 33;
  localparam int unsigned AOP_BITS    = 5;
  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned NUM_TBL     = 3;
  localparam int unsigned KEY_BITS    = AOP_BITS + ID_BITS + 32;

  localparam logic [OP_BITS-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_RR    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_RI    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_OTHER = 3'd3;
  localparam logic [OP_BITS-1:0] OP_BLOCK = 3'd4;

  localparam logic REG_ADD_OPCODE = 1'b0;
  localparam logic REG_MUL_OPCODE = 1'b1;

  typedef enum logic [1:0] {
    ACT_PASS      = 2'd0,
    ACT_RECORDED  = 2'd1,
    ACT_REDUNDANT = 2'd2,
    ACT_REMOVED   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_LOOKUP,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [1:0] {
    TBL_LOAD  = 2'd0,
    TBL_PAIR  = 2'd1,
    TBL_IMMOP = 2'd2
  } tbl_e;

  typedef struct packed {
    logic [AOP_BITS-1:0] add_op;
    logic [AOP_BITS-1:0] mul_op;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    cmd_e                cmd;
    tbl_e                tbl;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  dest;
    logic                done;
    action_e             action;
    logic [ID_BITS-1:0]  repl;
  } token_t;

endpackage

// ===== src/lvn_front.sv =====
// lvn_front: decodes one instruction word into a chain token, builds the
// expression key and settles the cases that need no table. Uses lvn_pkg.
module lvn_front import lvn_pkg::*; (
  input  logic                       start,
  input  cfg_t                       cfg_i,
  input  logic [OP_BITS-1:0]         op_i,
  input  logic [ID_BITS-1:0]         dest_id_i,
  input  logic [ID_BITS-1:0]         src1_id_i,
  input  logic [ID_BITS-1:0]         src2_id_i,
  input  logic [AOP_BITS-1:0]        alu_op_i,
  input  logic signed [IMM_BITS-1:0] imm_value_i,
  input  logic                       imm_is_ref_i,
  input  logic                       dest_is_vreg_i,
  input  logic                       src1_is_vreg_i,
  input  logic                       src2_is_vreg_i,
  input  logic                       dest_multi_def_i,
  input  logic                       dest_unused_i,
  output token_t                     tok_o
);

  logic               commut;
  logic               swap;
  logic [ID_BITS-1:0] lo_id;
  logic [ID_BITS-1:0] hi_id;

  assign commut = (alu_op_i == cfg_i.add_op) || (alu_op_i == cfg_i.mul_op);
  assign swap   = commut && (src1_id_i > src2_id_i);
  assign lo_id  = swap ? src2_id_i : src1_id_i;
  assign hi_id  = swap ? src1_id_i : src2_id_i;

  always_comb begin
    tok_o        = '0;
    tok_o.valid  = start;
    tok_o.cmd    = CMD_PASS;
    tok_o.tbl    = TBL_LOAD;
    tok_o.dest   = dest_id_i;
    tok_o.done   = 1'b1;
    tok_o.action = ACT_PASS;
    unique case (op_i)
      OP_BLOCK: begin
        tok_o.cmd = CMD_CLEAR;
      end
      OP_LOAD: begin
        if (dest_is_vreg_i) begin
          if (dest_unused_i) begin
            tok_o.action = ACT_REMOVED;
          end else if (!dest_multi_def_i) begin
            tok_o.cmd  = CMD_LOOKUP;
            tok_o.tbl  = TBL_LOAD;
            tok_o.done = 1'b0;
            tok_o.key  = KEY_BITS'({imm_is_ref_i, imm_value_i});
          end
        end
      end
      OP_RR: begin
        if (!dest_multi_def_i && dest_is_vreg_i && src1_is_vreg_i && src2_is_vreg_i) begin
          tok_o.cmd  = CMD_LOOKUP;
          tok_o.tbl  = TBL_PAIR;
          tok_o.done = 1'b0;
          tok_o.key  = KEY_BITS'({alu_op_i, lo_id, hi_id});
        end
      end
      OP_RI: begin
        if (!dest_multi_def_i && dest_is_vreg_i && src1_is_vreg_i) begin
          tok_o.cmd  = CMD_LOOKUP;
          tok_o.tbl  = TBL_IMMOP;
          tok_o.done = 1'b0;
          tok_o.key  = KEY_BITS'({alu_op_i, src1_id_i, imm_value_i[31:0]});
        end
      end
      OP_OTHER: begin
        tok_o.cmd = CMD_PASS;
      end
      default: begin
        tok_o.cmd = CMD_PASS;
      end
    endcase
  end

endmodule

// ===== src/lvn_cell.sv =====
// lvn_cell: one entry of each of the three expression tables; matches or
// claims its entry for the passing token and hands the token on. Uses lvn_pkg.
module lvn_cell import lvn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  token_t tok_i,
  output token_t tok_o
);

  logic [NUM_TBL-1:0]  valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q [NUM_TBL];
  logic [ID_BITS-1:0]  reg_q [NUM_TBL];
  logic [NUM_TBL-1:0]  hit;
  logic [NUM_TBL-1:0]  ins;
  logic                active;
  token_t              tok_d, tok_q;

  assign active = tok_i.valid && (tok_i.cmd == CMD_LOOKUP) && !tok_i.done;

  always_comb begin
    tok_d = tok_i;
    for (int t = 0; t < NUM_TBL; t++) begin
      hit[t] = active && (tok_i.tbl == tbl_e'(t)) && valid_q[t] && (key_q[t] == tok_i.key);
      ins[t] = active && (tok_i.tbl == tbl_e'(t)) && !valid_q[t];
      if (tok_i.valid && (tok_i.cmd == CMD_CLEAR)) begin
        valid_d[t] = 1'b0;
      end else begin
        valid_d[t] = valid_q[t] | ins[t];
      end
      if (hit[t]) begin
        tok_d.done   = 1'b1;
        tok_d.action = ACT_REDUNDANT;
        tok_d.repl   = reg_q[t];
      end
      if (ins[t]) begin
        tok_d.done   = 1'b1;
        tok_d.action = ACT_RECORDED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < NUM_TBL; t++) begin
      if (ins[t]) begin
        key_q[t] <= tok_i.key;
        reg_q[t] <= tok_i.dest;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== src/local_value_numbering_table.sv =====
// local_value_numbering_table: front decode, config registers and a chain of
// TABLE_DEPTH cells. A word moves through the cell registers in order to the done_o
// strobe, one cell per cycle; a new word is accepted every cycle, busy stays low.
// Reset clears every table valid bit and loads add_opcode 0, mul_opcode 1.
// A block start word clears each cell as it passes, in order with other words.
// Uses lvn_pkg, lvn_front, lvn_cell.
module local_value_numbering_table import lvn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_BITS-1:0]         op_i,
  input  logic [ID_BITS-1:0]         dest_id_i,
  input  logic [ID_BITS-1:0]         src1_id_i,
  input  logic [ID_BITS-1:0]         src2_id_i,
  input  logic [AOP_BITS-1:0]        alu_op_i,
  input  logic signed [IMM_BITS-1:0] imm_value_i,
  input  logic                       imm_is_ref_i,
  input  logic                       dest_is_vreg_i,
  input  logic                       src1_is_vreg_i,
  input  logic                       src2_is_vreg_i,
  input  logic                       dest_multi_def_i,
  input  logic                       dest_unused_i,
  output logic                       done_o,
  output logic [1:0]                 action_o,
  output logic [ID_BITS-1:0]         replacement_id_o,
  output logic                       table_full_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cfg_t   cfg_q, cfg_d;
  token_t chain [TABLE_DEPTH+1];
  token_t last;
  logic   full;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ADD_OPCODE) begin
        cfg_d.add_op = pwdata[AOP_BITS-1:0];
      end else begin
        cfg_d.mul_op = pwdata[AOP_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.add_op <= AOP_BITS'(0);
      cfg_q.mul_op <= AOP_BITS'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = (paddr[2] == REG_ADD_OPCODE) ? 32'(cfg_q.add_op) : 32'(cfg_q.mul_op);

  lvn_front u_front (
    .start           (start),
    .cfg_i           (cfg_q),
    .op_i            (op_i),
    .dest_id_i       (dest_id_i),
    .src1_id_i       (src1_id_i),
    .src2_id_i       (src2_id_i),
    .alu_op_i        (alu_op_i),
    .imm_value_i     (imm_value_i),
    .imm_is_ref_i    (imm_is_ref_i),
    .dest_is_vreg_i  (dest_is_vreg_i),
    .src1_is_vreg_i  (src1_is_vreg_i),
    .src2_is_vreg_i  (src2_is_vreg_i),
    .dest_multi_def_i(dest_multi_def_i),
    .dest_unused_i   (dest_unused_i),
    .tok_o           (chain[0])
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lvn_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  assign last             = chain[TABLE_DEPTH];
  assign full             = (last.cmd == CMD_LOOKUP) && !last.done;
  assign done_o           = last.valid;
  assign action_o         = full ? ACT_PASS : last.action;
  assign replacement_id_o = last.repl;
  assign table_full_o     = last.valid && full;

`ifndef SYNTHESIS
  a_full_is_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (action_o == ACT_PASS))
    else $error("table full word not reported as pass");

  a_repl_only_redundant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (action_o != ACT_REDUNDANT)) |-> (replacement_id_o == '0))
    else $error("replacement id set on non-redundant word");

  a_lookup_resolved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (last.cmd == CMD_LOOKUP) && !table_full_o) |->
      ((action_o == ACT_RECORDED) || (action_o == ACT_REDUNDANT)))
    else $error("lookup word left the chain unresolved");
`endif

endmodule
